>>> sv/scc_pkg.sv
// Package for the sector cache replacement controller.
// Holds sizes, status, opcode and fill codes. No dependencies.
package scc_pkg;
  localparam int unsigned Entries    = 64;
  localparam int unsigned SlotBits   = $clog2(Entries);
  localparam int unsigned ReaderBits = 8;
  localparam logic [ReaderBits-1:0] ReaderMax = '1;

  typedef enum logic [1:0] {
    OpOpen  = 2'd0,
    OpClose = 2'd1,
    OpFlush = 2'd2,
    OpRsvd  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    StHit       = 4'd0,
    StFree      = 4'd1,
    StEvict     = 4'd2,
    StBusy      = 4'd3,
    StNoVictim  = 4'd4,
    StBad       = 4'd5,
    StClosed    = 4'd6,
    StNotCached = 4'd7,
    StFlushed   = 4'd8,
    StNothing   = 4'd9
  } status_e;

  localparam logic [1:0] FillNone = 2'd0;
  localparam logic [1:0] FillRead = 2'd1;
  localparam logic [1:0] FillZero = 2'd2;

  typedef struct packed {
    logic [3:0]          status;
    logic [SlotBits-1:0] slot;
    logic [31:0]         sector;
    logic                writeback;
    logic [1:0]          fill;
    logic                last;
  } result_t;
endpackage

>>> sv/scc_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module scc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

>>> sv/sector_cache_clock_replacement.sv
// Top level of the sector cache tag and clock replacement controller.
// Depends on scc_pkg and scc_ram (tag and reader count store).
//
// One word is taken on s_axis and answered with one or more result words on
// m_axis. The tags and reader counts live in a single-port RAM, so every
// step walks one entry. A lookup scans entries in order, reading each one and
// then comparing it. On a miss the flag bits are scanned for a free slot at
// one entry per cycle. If no slot is free, the clock sweep runs for up to two
// rounds of the hand, reading and then deciding at each step. A claimed slot
// then has its tag written in a separate claim state. Flush walks all entries,
// reading and checking each, and releases a held flushed word before it looks
// at the next dirty entry again. It also stalls while a flushed word waits on
// m_axis. The input is not ready while a request is in progress. A result
// register holds each word until it is taken. Set the pinned sector through
// cfg_we_i and cfg_wdata_i, and only while the block is idle.
module sector_cache_clock_replacement (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: opcode[1:0], sector[33:2], write[34], create[35], zeros to 39
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: status[3:0], slot[9:4], sector_out[41:10], writeback[42],
  // fill[44:43], zeros to 47
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tlast
);
  import scc_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LRD   = 4'd1;  // lookup: read tag
  localparam logic [3:0] S_LCMP  = 4'd2;  // lookup: compare
  localparam logic [3:0] S_FREE  = 4'd3;  // free slot scan
  localparam logic [3:0] S_SRD   = 4'd4;  // sweep: read tag at hand
  localparam logic [3:0] S_SCMP  = 4'd5;  // sweep: decide
  localparam logic [3:0] S_FRD   = 4'd6;  // flush: read tag
  localparam logic [3:0] S_FCMP  = 4'd7;  // flush: emit
  localparam logic [3:0] S_OUT   = 4'd8;  // wait for final word taken
  localparam logic [3:0] S_CLAIM = 4'd9;  // write tag of claimed slot

  localparam int unsigned EntBits = 32 + ReaderBits;
  localparam logic [SlotBits-1:0] LastSlot = SlotBits'(Entries - 1);
  localparam logic [SlotBits+1:0] LastStep = (SlotBits+2)'(2 * Entries - 1);

  logic [3:0] state_q;
  logic [31:0] pin_q;
  logic [Entries-1:0] valid_q, acc_q, dirty_q, wr_q;
  logic [SlotBits-1:0] hand_q, idx_q;
  logic [SlotBits+1:0] steps_q;
  logic [1:0] op_q;
  logic [31:0] sec_q;
  // flushed_q marks a flushed word held in res_q that is not yet released.
  logic wrr_q, cr_q, flushed_q;
  result_t res_q;
  logic out_v_q, out_set;

  // Each RAM word holds the reader count above the tag.
  logic ent_we;
  logic [SlotBits-1:0] ent_addr;
  logic [EntBits-1:0] ent_wdata, ent_rd;
  logic [31:0] tag_rd;
  logic [ReaderBits-1:0] rc_rd, rc_claim, rc_next;

  scc_ram #(.Width(EntBits), .Depth(Entries)) u_tag (
    .clk_i(clk_i), .we_i(ent_we), .addr_i(ent_addr),
    .wdata_i(ent_wdata), .rdata_o(ent_rd)
  );

  assign tag_rd = ent_rd[31:0];
  assign rc_rd  = ent_rd[EntBits-1:32];

  logic in_acc, in_bad, lk_hit, lk_last;
  logic held_hand, sw_pin, sw_skip, sw_last, flush_hit;
  logic rc_inc, rc_dec, out_free;
  logic [1:0] fill_code;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign in_bad = (s_axis_tdata[1:0] == OpRsvd) ||
                  ((s_axis_tdata[1:0] == OpOpen) && s_axis_tdata[35] && !s_axis_tdata[34]);

  assign lk_hit    = valid_q[idx_q] && (tag_rd == sec_q);
  assign lk_last   = (idx_q == LastSlot);
  assign held_hand = wr_q[hand_q] || (rc_rd != '0);
  assign sw_pin    = valid_q[hand_q] && (tag_rd == pin_q);
  assign sw_skip   = sw_pin || acc_q[hand_q] || held_hand;
  assign sw_last   = (steps_q == LastStep);
  assign flush_hit = valid_q[idx_q] && dirty_q[idx_q] && !wr_q[idx_q];

  // Reader count updates are written back to the entry during the compare.
  assign rc_inc = (state_q == S_LCMP) && lk_hit && (op_q == OpOpen) && !cr_q &&
                  !wrr_q && !wr_q[idx_q] && (rc_rd != ReaderMax);
  assign rc_dec = (state_q == S_LCMP) && lk_hit && (op_q == OpClose) && !wrr_q &&
                  (rc_rd != '0);

  assign rc_claim  = wrr_q ? '0 : ReaderBits'(1);
  assign rc_next   = rc_inc ? rc_rd + ReaderBits'(1) : rc_rd - ReaderBits'(1);
  assign ent_we    = (state_q == S_CLAIM) || rc_inc || rc_dec;
  assign ent_wdata = (state_q == S_CLAIM) ? {rc_claim, sec_q} : {rc_next, tag_rd};
  assign ent_addr  = (state_q == S_SRD) ? hand_q : idx_q;

  assign s_axis_tready = (state_q == S_IDLE) && !out_v_q;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tlast  = res_q.last;
  assign m_axis_tdata  = {3'b0, res_q.fill, res_q.writeback, res_q.sector,
                          res_q.slot, res_q.status};

  assign out_free = !out_v_q || m_axis_tready;

  assign fill_code = cr_q ? FillZero : FillRead;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_q <= '0;
    end else if (cfg_we_i) begin
      pin_q <= cfg_wdata_i;
    end
  end

  // A result word is flagged when res_q is loaded with it, in the claim state for a word
  // loaded earlier, or when a flushed word already held there is released.
  always_comb begin
    unique case (state_q)
      S_IDLE:  out_set = in_acc && in_bad;
      S_LCMP:  out_set = lk_hit || (lk_last && (op_q != OpOpen));
      S_SCMP:  out_set = sw_skip && sw_last;
      S_CLAIM: out_set = 1'b1;
      S_FCMP:  out_set = out_free && ((flush_hit && flushed_q) || lk_last);
      default: out_set = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_set) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  function automatic result_t mk(status_e st, logic [SlotBits-1:0] sl);
    result_t r;
    r = '0;
    r.status = st;
    r.slot = sl;
    r.last = 1'b1;
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      valid_q   <= '0;
      acc_q     <= '0;
      dirty_q   <= '0;
      wr_q      <= '0;
      hand_q    <= '0;
      idx_q     <= '0;
      steps_q   <= '0;
      flushed_q <= 1'b0;
      op_q      <= '0;
      sec_q     <= '0;
      wrr_q     <= 1'b0;
      cr_q      <= 1'b0;
      res_q     <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            op_q  <= s_axis_tdata[1:0];
            sec_q <= s_axis_tdata[33:2];
            wrr_q <= s_axis_tdata[34];
            cr_q  <= s_axis_tdata[35];
            idx_q <= '0;
            flushed_q <= 1'b0;
            // An open with create but without write, and the reserved opcode, answer at once.
            priority if (in_bad) begin
              res_q <= mk(StBad, '0);
            end else if (s_axis_tdata[1:0] == OpFlush) begin
              state_q <= S_FRD;
            end else begin
              state_q <= S_LRD;
            end
          end
        end
        S_LRD: state_q <= S_LCMP;
        S_LCMP: begin
          if (lk_hit) begin
            state_q <= S_OUT;
            if (op_q == OpOpen) begin
              if (cr_q) begin
                res_q <= mk(StBad, '0);
              end else if (wr_q[idx_q] || (wrr_q && rc_rd != '0) ||
                           (!wrr_q && rc_rd == ReaderMax)) begin
                res_q <= mk(StBusy, idx_q);
              end else begin
                if (wrr_q) begin
                  wr_q[idx_q] <= 1'b1;
                  dirty_q[idx_q] <= 1'b1;
                end
                acc_q[idx_q] <= 1'b1;
                res_q <= mk(StHit, idx_q);
              end
            end else begin
              if (wrr_q ? !wr_q[idx_q] : (rc_rd == '0)) begin
                res_q <= mk(StBad, idx_q);
              end else begin
                if (wrr_q) wr_q[idx_q] <= 1'b0;
                res_q <= mk(StClosed, idx_q);
              end
            end
          end else if (lk_last) begin
            idx_q <= '0;
            if (op_q == OpOpen) begin
              state_q <= S_FREE;
            end else begin
              res_q <= mk(StNotCached, '0);
              state_q <= S_OUT;
            end
          end else begin
            idx_q <= idx_q + 1'b1;
            state_q <= S_LRD;
          end
        end
        S_FREE: begin
          // An entry that was never claimed has no holder, so the valid bit
          // alone decides whether the slot is free.
          if (!valid_q[idx_q]) begin
            res_q <= '{status: StFree, slot: idx_q, sector: '0,
                       writeback: 1'b0, fill: fill_code, last: 1'b1};
            state_q <= S_CLAIM;
          end else if (lk_last) begin
            steps_q <= '0;
            state_q <= S_SRD;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_SRD: state_q <= S_SCMP;
        S_SCMP: begin
          hand_q <= (hand_q == LastSlot) ? '0 : hand_q + 1'b1;
          steps_q <= steps_q + 1'b1;
          if (sw_skip) begin
            // The pinned entry keeps its accessed bit; other skipped entries
            // lose theirs.
            if (!sw_pin) acc_q[hand_q] <= 1'b0;
            if (sw_last) begin
              res_q <= mk(StNoVictim, '0);
              state_q <= S_OUT;
            end else begin
              state_q <= S_SRD;
            end
          end else begin
            idx_q <= hand_q;
            res_q <= '{status: StEvict, slot: hand_q,
                       sector: (valid_q[hand_q] && dirty_q[hand_q]) ? tag_rd : '0,
                       writeback: valid_q[hand_q] && dirty_q[hand_q],
                       fill: fill_code, last: 1'b1};
            state_q <= S_CLAIM;
          end
        end
        S_CLAIM: begin
          valid_q[idx_q] <= 1'b1;
          acc_q[idx_q]   <= 1'b1;
          dirty_q[idx_q] <= wrr_q;
          if (wrr_q) wr_q[idx_q] <= 1'b1;
          state_q <= S_OUT;
        end
        S_FRD: state_q <= S_FCMP;
        S_FCMP: begin
          if (out_free) begin
            // A flushed word waits in res_q until the next dirty entry or the
            // end of the walk shows whether it is the last one.
            if (flush_hit && flushed_q) begin
              // Release the held word and look at this entry again.
              flushed_q <= 1'b0;
            end else if (lk_last) begin
              state_q <= S_OUT;
              if (flush_hit) begin
                dirty_q[idx_q] <= 1'b0;
                res_q <= '{status: StFlushed, slot: idx_q, sector: tag_rd,
                           writeback: 1'b1, fill: FillNone, last: 1'b1};
              end else if (flushed_q) begin
                res_q.last <= 1'b1;
              end else begin
                res_q <= mk(StNothing, '0);
              end
            end else begin
              idx_q <= idx_q + 1'b1;
              state_q <= S_FRD;
              if (flush_hit) begin
                dirty_q[idx_q] <= 1'b0;
                flushed_q <= 1'b1;
                res_q <= '{status: StFlushed, slot: idx_q, sector: tag_rd,
                           writeback: 1'b1, fill: FillNone, last: 1'b0};
              end
            end
          end
        end
        S_OUT: begin
          if (!out_v_q || (m_axis_tready && res_q.last)) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // A claimed slot ends up valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLAIM |=> valid_q[$past(idx_q)])
    else $error("claimed slot not valid");
  // An entry is never held by a writer and readers at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LCMP) && lk_hit |-> !(wr_q[idx_q] && rc_rd != '0))
    else $error("writer and readers together");
  // No new request while a word is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> !s_axis_tready)
    else $error("ready while result pending");
  // A new result word is only loaded when the output register is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_set |-> out_free)
    else $error("result word overwritten");
endmodule
